>>> design/aiss_pkg.sv
package aiss_pkg;

  localparam logic [7:0] PortInOne       = 8'd1;
  localparam logic [7:0] PortInTwo       = 8'd2;
  localparam logic [7:0] PortShiftIn     = 8'd3;
  localparam logic [7:0] PortShiftAmount = 8'd2;
  localparam logic [7:0] PortSoundOne    = 8'd3;
  localparam logic [7:0] PortShiftData   = 8'd4;
  localparam logic [7:0] PortSoundTwo    = 8'd5;
  localparam logic [7:0] PortWatchdog    = 8'd6;

  localparam logic ModeRead  = 1'b0;
  localparam logic ModeWrite = 1'b1;

  localparam int CfgAddrWidth = 4;
  localparam logic [CfgAddrWidth-1:0] AddrShips     = 4'h0;
  localparam logic [CfgAddrWidth-1:0] AddrExtraLife = 4'h4;
  localparam logic [CfgAddrWidth-1:0] AddrCoinInfo  = 4'h8;

  localparam logic [7:0] AmpBit      = 8'h20;
  localparam logic [7:0] FlipBit     = 8'h20;
  localparam logic [7:0] UfoDestroyBit = 8'h10;

  typedef struct packed {
    logic       mode;
    logic [7:0] port_number;
    logic [7:0] write_data;
    logic       coin_switch;
    logic       one_player_start;
    logic       two_player_start;
    logic [2:0] player_one_buttons;
    logic [2:0] player_two_buttons;
    logic       tilt_switch;
  } aiss_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [6:0] sound_one_events;
    logic [4:0] sound_two_events;
    logic       cocktail_flip;
  } aiss_rsp_t;

endpackage

>>> design/arcade_io_shifter_sound_ports.sv
// processor i/o port block with external barrel shifter and sound latches
//
// req channel (valid/ready) carries one port transaction: mode, port number,
// write byte and the current panel switch levels. rsp channel (valid/ready)
// returns one result per transaction: read byte, sound event pulses for the
// two sound banks and the cocktail flip latch after the transaction.
//
// the result is registered: it appears in the output register in the cycle after
// the request is accepted. throughput: one transaction per cycle while results
// are taken; decode, shift select and sound edge compare are a single
// combinational pass between the request handshake and the result register.
//
// a new request is taken whenever the result register is empty or is being
// drained in the same cycle, so a stalled receiver holds the result and
// backs up the request side only while the result is not taken.
//
// reset (synchronous, rst high) clears the shift register, shift amount,
// sound history, flip latch, dip settings and the result valid flag.
// the dip settings are written through the apb port at 0x0, 0x4 and 0x8.
module arcade_io_shifter_sound_ports (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  aiss_pkg::aiss_req_t                req,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output aiss_pkg::aiss_rsp_t                rsp,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [aiss_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import aiss_pkg::*;

  logic [1:0] ships_setting;
  logic       extra_life_setting;
  logic       coin_info_setting;

  logic [7:0] shift_high_byte;
  logic [7:0] shift_low_byte;
  logic [2:0] shift_count;
  logic [7:0] last_sound_one;
  logic [7:0] last_sound_two;
  logic       flip_latch;

  logic [7:0] shift_high_byte_next;
  logic [7:0] shift_low_byte_next;
  logic [2:0] shift_count_next;
  logic [7:0] last_sound_one_next;
  logic [7:0] last_sound_two_next;
  logic       flip_latch_next;
  aiss_rsp_t  rsp_next;

  logic        req_fire;
  logic        cfg_write;
  logic [15:0] shift_word;
  logic [7:0]  shift_result;
  logic [7:0]  rise_one;
  logic [7:0]  rise_two;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign req_ready = !rsp_valid || rsp_ready;
  assign req_fire  = req_valid && req_ready;

  always_comb begin
    prdata = '0;
    unique case (paddr)
      AddrShips:     prdata = {30'd0, ships_setting};
      AddrExtraLife: prdata = {31'd0, extra_life_setting};
      AddrCoinInfo:  prdata = {31'd0, coin_info_setting};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ships_setting      <= '0;
      extra_life_setting <= 1'b0;
      coin_info_setting  <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr)
        AddrShips:     ships_setting      <= pwdata[1:0];
        AddrExtraLife: extra_life_setting <= pwdata[0];
        AddrCoinInfo:  coin_info_setting  <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign shift_word   = {shift_high_byte, shift_low_byte};
  assign shift_result = shift_word[4'd15 - {1'b0, shift_count} -: 8];
  assign rise_one     = req.write_data & ~last_sound_one;
  assign rise_two     = req.write_data & ~last_sound_two;

  always_comb begin
    shift_high_byte_next = shift_high_byte;
    shift_low_byte_next  = shift_low_byte;
    shift_count_next     = shift_count;
    last_sound_one_next  = last_sound_one;
    last_sound_two_next  = last_sound_two;
    flip_latch_next      = flip_latch;
    rsp_next             = '0;
    if (req.mode == ModeRead) begin
      unique case (req.port_number)
        PortInOne: begin
          rsp_next.read_data = {1'b0, req.player_one_buttons, 1'b1, req.one_player_start,
                                req.two_player_start, ~req.coin_switch};
        end
        PortInTwo: begin
          rsp_next.read_data = {coin_info_setting, req.player_two_buttons,
                                extra_life_setting, req.tilt_switch, ships_setting};
        end
        PortShiftIn: rsp_next.read_data = shift_result;
        default: ;
      endcase
    end else begin
      unique case (req.port_number)
        PortShiftAmount: shift_count_next = req.write_data[2:0];
        PortShiftData: begin
          shift_low_byte_next  = shift_high_byte;
          shift_high_byte_next = req.write_data;
        end
        PortSoundOne: begin
          rsp_next.sound_one_events = {
            (|(last_sound_one & AmpBit)) && !(|(req.write_data & AmpBit)),
            |(rise_one & AmpBit),
            rise_one[4:1],
            req.write_data[0]
          };
          last_sound_one_next = req.write_data;
        end
        PortSoundTwo: begin
          rsp_next.sound_two_events = rise_two[4:0];
          flip_latch_next           = |(req.write_data & FlipBit);
          last_sound_two_next       = req.write_data;
        end
        PortWatchdog: ;
        default: ;
      endcase
    end
    rsp_next.cocktail_flip = flip_latch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_high_byte <= '0;
      shift_low_byte  <= '0;
      shift_count     <= '0;
      last_sound_one  <= '0;
      last_sound_two  <= '0;
      flip_latch      <= 1'b0;
      rsp_valid       <= 1'b0;
    end else begin
      if (req_fire) begin
        shift_high_byte <= shift_high_byte_next;
        shift_low_byte  <= shift_low_byte_next;
        shift_count     <= shift_count_next;
        last_sound_one  <= last_sound_one_next;
        last_sound_two  <= last_sound_two_next;
        flip_latch      <= flip_latch_next;
        rsp_valid       <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> tb/arcade_io_shifter_sound_ports_test.sv
module arcade_io_shifter_sound_ports_test;
  import aiss_pkg::*;

  localparam logic [9:0] PanelIdle = 10'h000;
  localparam logic [9:0] PanelAll = 10'h3FF;
  localparam logic [20:0] NoRsp = 21'h0;
  localparam int DirCount = 27;
  localparam int ItemsPerPhase = 200;
  localparam int ReqBits = $bits(aiss_req_t);

  typedef struct packed {
    aiss_req_t acc;
    logic      known;
    aiss_rsp_t rsp;
  } dir_row_t;

  dir_row_t directed_rows [DirCount] = '{
    {ModeRead, PortInOne, 8'h00, PanelIdle, 1'b1, 8'h09, 7'h00, 5'h00, 1'b0},
    {ModeRead, PortInOne, 8'hFF, PanelAll, 1'b1, 8'h7E, 7'h00, 5'h00, 1'b0},
    {ModeRead, PortInTwo, 8'h00, PanelAll, 1'b1, 8'h74, 7'h00, 5'h00, 1'b0},
    {ModeRead, PortInTwo, 8'hFF, PanelIdle, 1'b1, 8'h00, 7'h00, 5'h00, 1'b0},
    {ModeRead, PortShiftIn, 8'h00, PanelAll, 1'b1, 8'h00, 7'h00, 5'h00, 1'b0},
    {ModeRead, 8'h00, 8'hFF, PanelAll, 1'b1, 8'h00, 7'h00, 5'h00, 1'b0},
    {ModeRead, 8'hFF, 8'hFF, PanelAll, 1'b1, 8'h00, 7'h00, 5'h00, 1'b0},
    {ModeWrite, PortWatchdog, 8'hFF, PanelAll, 1'b1, 8'h00, 7'h00, 5'h00, 1'b0},
    {ModeWrite, 8'h00, 8'hFF, PanelIdle, 1'b1, 8'h00, 7'h00, 5'h00, 1'b0},
    {ModeWrite, 8'hFF, 8'h5A, PanelAll, 1'b1, 8'h00, 7'h00, 5'h00, 1'b0},
    {ModeWrite, PortShiftData, 8'hFF, PanelIdle, 1'b1, 8'h00, 7'h00, 5'h00, 1'b0},
    {ModeWrite, PortShiftData, 8'h00, PanelIdle, 1'b1, 8'h00, 7'h00, 5'h00, 1'b0},
    {ModeWrite, PortShiftAmount, 8'hFF, PanelIdle, 1'b1, 8'h00, 7'h00, 5'h00, 1'b0},
    {ModeRead, PortShiftIn, 8'h00, PanelIdle, 1'b0, NoRsp},
    {ModeWrite, PortShiftAmount, 8'hF8, PanelAll, 1'b1, 8'h00, 7'h00, 5'h00, 1'b0},
    {ModeRead, PortShiftIn, 8'h00, PanelAll, 1'b0, NoRsp},
    {ModeWrite, PortShiftData, 8'hA5, PanelIdle, 1'b1, 8'h00, 7'h00, 5'h00, 1'b0},
    {ModeWrite, PortShiftAmount, 8'h03, PanelIdle, 1'b1, 8'h00, 7'h00, 5'h00, 1'b0},
    {ModeRead, PortShiftIn, 8'h00, PanelIdle, 1'b0, NoRsp},
    {ModeWrite, PortSoundOne, 8'hFF, PanelIdle, 1'b1, 8'h00, 7'h3F, 5'h00, 1'b0},
    {ModeWrite, PortSoundOne, 8'hFF, PanelIdle, 1'b0, NoRsp},
    {ModeWrite, PortSoundOne, 8'h00, PanelIdle, 1'b0, NoRsp},
    {ModeWrite, PortSoundTwo, 8'hFF, PanelIdle, 1'b1, 8'h00, 7'h00, 5'h1F, 1'b1},
    {ModeWrite, PortSoundTwo, 8'hDF, PanelAll, 1'b0, NoRsp},
    {ModeWrite, PortInOne, 8'hFF, PanelAll, 1'b0, NoRsp},
    {ModeRead, PortSoundTwo, 8'hFF, PanelAll, 1'b0, NoRsp},
    {ModeRead, PortShiftData, 8'h00, PanelAll, 1'b0, NoRsp}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  aiss_req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  aiss_rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic known_row = 1'b0;
  aiss_rsp_t known_rsp = '0;
  int stall_pct = 18;
  int mismatches = 0;
  aiss_rsp_t port_results [$];

  logic [1:0] cfg_ships = '0;
  logic cfg_extra_life = 1'b0;
  logic cfg_coin_info = 1'b0;
  logic [7:0] sh_hi = '0;
  logic [7:0] sh_lo = '0;
  logic [2:0] sh_count = '0;
  logic [7:0] snd_one_last = '0;
  logic [7:0] snd_two_last = '0;
  logic flip_state = 1'b0;

  arcade_io_shifter_sound_ports uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial forever #2 clk = ~clk;

  initial begin
    #200000;
    $display("[arcade_io_shifter_sound_ports] ERROR");
    $finish;
  end

  function automatic aiss_rsp_t port_access(aiss_req_t a);
    aiss_rsp_t r;
    logic [15:0] word;
    logic [7:0] rise;
    r = '0;
    if (a.mode == ModeRead) begin
      case (a.port_number)
        PortInOne: r.read_data = {1'b0, a.player_one_buttons, 1'b1, a.one_player_start,
                                  a.two_player_start, ~a.coin_switch};
        PortInTwo: r.read_data = {cfg_coin_info, a.player_two_buttons, cfg_extra_life,
                                  a.tilt_switch, cfg_ships};
        PortShiftIn: begin
          word = {sh_hi, sh_lo} << sh_count;
          r.read_data = word[15:8];
        end
        default: ;
      endcase
    end else begin
      case (a.port_number)
        PortShiftAmount: sh_count = a.write_data[2:0];
        PortShiftData: begin
          sh_lo = sh_hi;
          sh_hi = a.write_data;
        end
        PortSoundOne: begin
          rise = a.write_data & ~snd_one_last;
          r.sound_one_events = {snd_one_last[5] & ~a.write_data[5], rise[5], rise[4:1],
                                a.write_data[0]};
          snd_one_last = a.write_data;
        end
        PortSoundTwo: begin
          rise = a.write_data & ~snd_two_last;
          r.sound_two_events = rise[4:0];
          flip_state = a.write_data[5];
          snd_two_last = a.write_data;
        end
        default: ;
      endcase
    end
    r.cocktail_flip = flip_state;
    return r;
  endfunction

  always @(negedge clk) rsp_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    aiss_rsp_t exp_rsp;
    aiss_rsp_t pred;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (port_results.size() == 0) begin
          $error("unexpected result transaction %h", rsp);
          mismatches++;
        end else begin
          exp_rsp = port_results.pop_front();
          if (rsp.read_data !== exp_rsp.read_data) begin
            $error("read_data expected %h actual %h", exp_rsp.read_data, rsp.read_data);
            mismatches++;
          end
          if (rsp.sound_one_events !== exp_rsp.sound_one_events) begin
            $error("sound_one_events expected %h actual %h",
                   exp_rsp.sound_one_events, rsp.sound_one_events);
            mismatches++;
          end
          if (rsp.sound_two_events !== exp_rsp.sound_two_events) begin
            $error("sound_two_events expected %h actual %h",
                   exp_rsp.sound_two_events, rsp.sound_two_events);
            mismatches++;
          end
          if (rsp.cocktail_flip !== exp_rsp.cocktail_flip) begin
            $error("cocktail_flip expected %b actual %b",
                   exp_rsp.cocktail_flip, rsp.cocktail_flip);
            mismatches++;
          end
        end
      end
      if (req_valid && req_ready) begin
        pred = port_access(req);
        port_results.push_back(known_row ? known_rsp : pred);
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_access(aiss_req_t a, logic known, aiss_rsp_t k_rsp);
    int gap;
    gap = 0;
    while ($urandom_range(99) < stall_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= a;
    known_row <= known;
    known_rsp <= k_rsp;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    while (port_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // write one setting, then read it back
  task automatic write_setting(logic [CfgAddrWidth-1:0] addr, logic [31:0] value,
                               logic [31:0] mask);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= ($urandom & ~mask) | value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      $error("prdata expected %h actual %h", value, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    aiss_req_t a;
    logic [1:0] ships;
    logic extra;
    logic coin;
    int kind;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_access(directed_rows[i].acc, directed_rows[i].known, directed_rows[i].rsp);

    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      ships = (ph == 0) ? 2'd3 : (ph == 1) ? 2'd0 : 2'($urandom_range(3));
      extra = (ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : 1'($urandom_range(1));
      coin = (ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : 1'($urandom_range(1));
      write_setting(AddrShips, {30'd0, ships}, 32'h3);
      cfg_ships = ships;
      write_setting(AddrExtraLife, {31'd0, extra}, 32'h1);
      cfg_extra_life = extra;
      write_setting(AddrCoinInfo, {31'd0, coin}, 32'h1);
      cfg_coin_info = coin;
      // no stalls on either side for the whole of one phase
      stall_pct = (ph == 2) ? 0 : 18;
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (ph == 0 && i == ItemsPerPhase / 2) drain_results();
        a = aiss_req_t'(ReqBits'($urandom));
        kind = $urandom_range(9);
        case (kind)
          0: begin a.mode = ModeRead; a.port_number = PortInOne; end
          1: begin a.mode = ModeRead; a.port_number = PortInTwo; end
          2: begin a.mode = ModeRead; a.port_number = PortShiftIn; end
          3: begin a.mode = ModeWrite; a.port_number = PortShiftAmount; end
          4: begin a.mode = ModeWrite; a.port_number = PortShiftData; end
          5: begin a.mode = ModeWrite; a.port_number = PortSoundOne; end
          6: begin a.mode = ModeWrite; a.port_number = PortSoundTwo; end
          7: begin a.mode = ModeWrite; a.port_number = PortWatchdog; end
          default: ;
        endcase
        send_access(a, 1'b0, '0);
      end
    end

    drain_results();
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("[arcade_io_shifter_sound_ports] OK");
    end else begin
      $display("[arcade_io_shifter_sound_ports] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
design/aiss_pkg.sv
design/arcade_io_shifter_sound_ports.sv
tb/arcade_io_shifter_sound_ports_test.sv
